// ===== src/ahfe_pkg.sv =====
package ahfe_pkg;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [7:0]  ESC_BYTE    = 8'h7D;
  localparam logic [7:0]  ESC_MASK    = 8'h20;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam int          QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } line_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_last;
    logic [15:0] fcs;
  } entry_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_FLAG
  } phase_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return b inside {FLAG_BYTE, ESC_BYTE};
  endfunction

endpackage

// ===== src/ahfe_front.sv =====
module ahfe_front import ahfe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  src_item_t src_item,
  input  logic      queue_full,
  output logic      push,
  output entry_t    push_entry
);

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] folded;

  assign src_stall = queue_full;
  assign push      = src_valid && !queue_full;
  assign folded    = crc_fold(crc, src_item.data_byte);
  assign crc_next  = src_item.is_last ? CRC_INIT : folded;

  always_comb begin
    push_entry.data_byte = src_item.data_byte;
    push_entry.is_last   = src_item.is_last;
    push_entry.fcs       = ~folded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (push) begin
      crc <= crc_next;
    end
  end

endmodule

// ===== src/ahfe_queue.sv =====
module ahfe_queue import ahfe_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/ahfe_back.sv =====
module ahfe_back import ahfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       line_valid,
  input  logic       line_stall,
  output line_item_t line_item
);

  phase_t     phase;
  phase_t     phase_next;
  logic       esc;
  logic       esc_next;
  logic       load;
  logic [7:0] cur_byte;
  logic       stuff;
  logic       byte_done;
  logic       item_done;
  line_item_t emit;

  assign load = head_valid && (!line_valid || !line_stall);
  assign pop  = load && item_done;

  // outputs of the sequencer
  always_comb begin
    case (phase)
      PH_DATA:   cur_byte = head.data_byte;
      PH_CRC_LO: cur_byte = head.fcs[7:0];
      PH_CRC_HI: cur_byte = head.fcs[15:8];
      PH_FLAG:   cur_byte = FLAG_BYTE;
      default:   cur_byte = FLAG_BYTE;
    endcase
    stuff     = (phase != PH_FLAG) && needs_escape(cur_byte);
    byte_done = esc || !stuff;
    item_done = byte_done && ((phase == PH_FLAG) || (phase == PH_DATA && !head.is_last));
    if (esc) begin
      emit.out_byte = cur_byte ^ ESC_MASK;
    end else if (stuff) begin
      emit.out_byte = ESC_BYTE;
    end else begin
      emit.out_byte = cur_byte;
    end
    emit.run_last  = item_done;
    emit.frame_end = (phase == PH_FLAG);
  end

  // next state
  always_comb begin
    phase_next = phase;
    esc_next   = esc;
    if (load) begin
      if (!byte_done) begin
        esc_next = 1'b1;
      end else begin
        esc_next = 1'b0;
        if (item_done) begin
          phase_next = PH_DATA;
        end else begin
          case (phase)
            PH_DATA:   phase_next = PH_CRC_LO;
            PH_CRC_LO: phase_next = PH_CRC_HI;
            PH_CRC_HI: phase_next = PH_FLAG;
            default:   phase_next = PH_DATA;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DATA;
      esc        <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      esc   <= esc_next;
      if (load) begin
        line_valid <= 1'b1;
      end else if (!line_stall) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_item <= emit;
    end
  end

endmodule

// ===== src/async_hdlc_frame_encoder.sv =====
// Async HDLC frame encoder. Each src item is one payload byte, is_last marking
// the final byte of a frame. Line items come out one byte per cycle while
// line_stall is low: the byte, or 0x7D then byte^0x20 for 0x7E/0x7D; after a
// final byte the inverted CRC-16/X.25 (low byte first, stuffed the same way)
// and a closing 0x7E flag with frame_end set. No opening flag is sent. run_last
// marks the last line item of each src item. An src item gives 1 to 7 line
// items (1 plain, 2 stuffed, up to 7 on a final byte); a small queue between
// the CRC front and the output sequencer takes new bytes while earlier ones
// are still going out, so plain bytes stream at one per cycle when not stalled.
module async_hdlc_frame_encoder import ahfe_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  src_item_t  src_item,
  output logic       line_valid,
  input  logic       line_stall,
  output line_item_t line_item
);

  logic   queue_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  ahfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ahfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ahfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_item  (line_item)
  );

endmodule
